/* hdl/rsc_pkg.sv */
// rsc_pkg: shared types and constants of the RPN stack calculator.
// Holds mode and status codes, shared-unit opcodes and the request/response
// structs. No dependencies.
package rsc_pkg;

	localparam int DATA_W  = 64;
	localparam int SHIFT_W = 128;

	localparam logic [DATA_W-1:0] MAX_POS = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic [DATA_W-1:0] MIN_NEG = {1'b1, {(DATA_W-1){1'b0}}};

	typedef enum logic [3:0] {
		MODE_PUSH  = 4'd0,
		MODE_ADD   = 4'd1,
		MODE_SUB   = 4'd2,
		MODE_MUL   = 4'd3,
		MODE_DIV   = 4'd4,
		MODE_ABS   = 4'd5,
		MODE_NEG   = 4'd6,
		MODE_INV   = 4'd7,
		MODE_SQR   = 4'd8,
		MODE_SQRT  = 4'd9,
		MODE_DROP  = 4'd10,
		MODE_CLEAR = 4'd11
	} mode_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_FEW     = 3'd1,
		ST_DIV0    = 3'd2,
		ST_SQRTNEG = 3'd3,
		ST_FULL    = 3'd4,
		ST_SAT     = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		ALU_ADD,
		ALU_SUB,
		ALU_MUL,
		ALU_DIV,
		ALU_NEG,
		ALU_SQRT
	} alu_op_t;

	// a is the left operand (next), b the right operand (top); unary ops use b
	typedef struct packed {
		alu_op_t             op;
		logic [DATA_W-1:0]   a;
		logic [DATA_W-1:0]   b;
	} alu_req_t;

	typedef struct packed {
		logic                done;
		logic                sat;
		logic [DATA_W-1:0]   value;
	} alu_rsp_t;

endpackage

/* hdl/rsc_ram.sv */
// rsc_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module rsc_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* hdl/rsc_alu.sv */
// rsc_alu: shared iterative arithmetic unit around one 66-bit adder.
// Add, subtract and negate in one step; multiply, divide and square root
// one bit per cycle. Depends on rsc_pkg.
module rsc_alu #(
	parameter int FRAC_BITS = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              go,
	input  rsc_pkg::alu_req_t req,
	output rsc_pkg::alu_rsp_t rsp
);
	import rsc_pkg::*;

	localparam int QW     = DATA_W + FRAC_BITS;
	localparam int CNT_W  = $clog2(QW + 1);
	localparam int ROOT_W = DATA_W - 1;
	localparam logic [SHIFT_W-1:0] QMASK = (SHIFT_W'(1) << QW) - SHIFT_W'(1);

	typedef enum logic [2:0] {A_IDLE, A_ONE, A_MAGA, A_MAGB, A_RUN, A_FIN} astate_t;

	astate_t             state_q;
	alu_op_t             op_q;
	logic [DATA_W-1:0]   a_q;
	logic [DATA_W-1:0]   b_q;
	logic                negr_q;
	logic [DATA_W:0]     acc_q;
	logic [SHIFT_W-1:0]  shf_q;
	logic [ROOT_W-1:0]   root_q;
	logic [CNT_W-1:0]    cnt_q;
	alu_rsp_t            rsp_q;

	logic [65:0]         add_a;
	logic [65:0]         add_b;
	logic                add_sub;
	logic [66:0]         add_y;
	logic [SHIFT_W-1:0]  prod;
	logic [SHIFT_W-1:0]  mag;
	logic [DATA_W-1:0]   limit;
	logic                over;
	logic [DATA_W-1:0]   fin_value;
	logic                one_ovf;
	logic [DATA_W-1:0]   one_value;
	logic [DATA_W-1:0]   mag_b;

	assign add_y = {1'b0, add_a} + {1'b0, (add_sub ? ~add_b : add_b)} + 67'(add_sub);

	assign prod  = {acc_q[DATA_W-1:0], shf_q[DATA_W-1:0]};
	assign mag   = (op_q == ALU_MUL) ? (prod >> FRAC_BITS) : (shf_q & QMASK);
	assign limit = negr_q ? MIN_NEG : MAX_POS;
	assign over  = (|mag[SHIFT_W-1:DATA_W]) || (mag[DATA_W-1:0] > limit);
	assign mag_b = b_q[DATA_W-1] ? add_y[DATA_W-1:0] : b_q;

	always_comb begin
		if (op_q == ALU_SQRT) begin
			fin_value = {1'b0, root_q};
		end else if (over) begin
			fin_value = limit;
		end else if (negr_q) begin
			fin_value = add_y[DATA_W-1:0];
		end else begin
			fin_value = mag[DATA_W-1:0];
		end
	end

	// result fits 64 bits only when the top three bits agree
	assign one_ovf   = !(add_y[65:63] == 3'b000 || add_y[65:63] == 3'b111);
	assign one_value = one_ovf ? (add_y[65] ? MIN_NEG : MAX_POS) : add_y[DATA_W-1:0];

	// adder operand selection
	always_comb begin
		add_a   = '0;
		add_b   = '0;
		add_sub = 1'b0;
		case (state_q)
			A_ONE: begin
				add_b = {{2{b_q[DATA_W-1]}}, b_q};
				if (op_q == ALU_ADD || op_q == ALU_SUB) begin
					add_a = {{2{a_q[DATA_W-1]}}, a_q};
				end
				add_sub = (op_q != ALU_ADD);
			end
			A_MAGA: begin
				add_b   = {2'b00, a_q};
				add_sub = 1'b1;
			end
			A_MAGB: begin
				add_b   = {2'b00, b_q};
				add_sub = 1'b1;
			end
			A_RUN: begin
				case (op_q)
					ALU_MUL: begin
						add_a = {2'b00, acc_q[DATA_W-1:0]};
						add_b = shf_q[0] ? {2'b00, a_q} : '0;
					end
					ALU_DIV: begin
						add_a   = {1'b0, acc_q[DATA_W-1:0], shf_q[QW-1]};
						add_b   = {2'b00, b_q};
						add_sub = 1'b1;
					end
					default: begin
						add_a   = {acc_q[DATA_W-1:0], shf_q[SHIFT_W-3:SHIFT_W-4]};
						add_b   = {1'b0, root_q, 2'b01};
						add_sub = 1'b1;
					end
				endcase
			end
			A_FIN: begin
				add_b   = {2'b00, mag[DATA_W-1:0]};
				add_sub = 1'b1;
			end
			default: begin
				add_sub = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= A_IDLE;
			rsp_q.done <= 1'b0;
		end else begin
			rsp_q.done <= 1'b0;
			unique case (state_q)
				A_IDLE: begin
					if (go) begin
						op_q   <= req.op;
						a_q    <= req.a;
						b_q    <= req.b;
						negr_q <= req.a[DATA_W-1] ^ req.b[DATA_W-1];
						acc_q  <= '0;
						root_q <= '0;
						case (req.op)
							ALU_MUL, ALU_DIV: state_q <= A_MAGA;
							ALU_SQRT: begin
								shf_q   <= SHIFT_W'(req.b) << FRAC_BITS;
								cnt_q   <= CNT_W'(ROOT_W - 1);
								state_q <= A_RUN;
							end
							default: state_q <= A_ONE;
						endcase
					end
				end
				A_ONE: begin
					rsp_q.value <= one_value;
					rsp_q.sat   <= one_ovf;
					rsp_q.done  <= 1'b1;
					state_q     <= A_IDLE;
				end
				A_MAGA: begin
					if (a_q[DATA_W-1]) begin
						a_q <= add_y[DATA_W-1:0];
					end
					state_q <= A_MAGB;
				end
				A_MAGB: begin
					b_q <= mag_b;
					if (op_q == ALU_MUL) begin
						shf_q <= SHIFT_W'(mag_b);
						cnt_q <= CNT_W'(DATA_W - 1);
					end else begin
						shf_q <= SHIFT_W'(a_q) << FRAC_BITS;
						cnt_q <= CNT_W'(QW - 1);
					end
					state_q <= A_RUN;
				end
				A_RUN: begin
					case (op_q)
						ALU_MUL: begin
							acc_q <= {1'b0, add_y[DATA_W:1]};
							shf_q <= {shf_q[SHIFT_W-1:DATA_W], add_y[0], shf_q[DATA_W-1:1]};
						end
						ALU_DIV: begin
							if (add_y[66]) begin
								acc_q <= {1'b0, add_y[DATA_W-1:0]};
							end else begin
								acc_q <= {1'b0, add_a[DATA_W-1:0]};
							end
							shf_q <= {shf_q[SHIFT_W-2:0], add_y[66]};
						end
						default: begin
							if (add_y[66]) begin
								acc_q <= add_y[DATA_W:0];
							end else begin
								acc_q <= add_a[DATA_W:0];
							end
							root_q <= {root_q[ROOT_W-2:0], add_y[66]};
							shf_q  <= {shf_q[SHIFT_W-3:0], 2'b00};
						end
					endcase
					if (cnt_q == '0) begin
						state_q <= A_FIN;
					end else begin
						cnt_q <= cnt_q - CNT_W'(1);
					end
				end
				A_FIN: begin
					rsp_q.value <= fin_value;
					rsp_q.sat   <= (op_q != ALU_SQRT) && over;
					rsp_q.done  <= 1'b1;
					state_q     <= A_IDLE;
				end
				default: state_q <= A_IDLE;
			endcase
		end
	end

	assign rsp = rsp_q;

endmodule

/* hdl/rpn_stack_calculator.sv */
// rpn_stack_calculator: top level of the reverse-Polish Q32.32 calculator.
// Depends on rsc_pkg, rsc_ram (operand stack) and rsc_alu (shared unit).
//
//  channel   handshake          payload
//  --------  -----------------  -----------------------------------------
//  command   start / busy       mode, operand_value
//  result    done (strobe)      top_value, stack_count, status
//
// One command beat gives exactly one result beat, shown for one cycle with
// done high; the receiver cannot stall it.
// Push, clear, abs of a non-negative top, drop to empty and errors caught
// at accept go straight to the result; drop with entries left and div by
// a zero top read the stack first; add, sub, mul and div by a nonzero top
// read it and then wait on the shared unit; abs of a negative top, neg,
// sqr, inv and sqrt wait on the shared unit directly. The shared unit
// resolves mul, div and sqrt one result bit per cycle. The next beat can
// be taken once the result cycle has ended.
// busy stays high from the accepted beat until the result cycle ends.
// Reset clears the stack count; stack contents are left as they are.
module rpn_stack_calculator #(
	parameter int STACK_DEPTH = 16,
	parameter int FRAC_BITS   = 32
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic [3:0]                           mode,
	input  logic signed [63:0]                   operand_value,
	output logic                                 done,
	output logic signed [63:0]                   top_value,
	output logic [$clog2(STACK_DEPTH+1)-1:0]     stack_count,
	output logic [2:0]                           status
);
	import rsc_pkg::*;

	localparam int AW = $clog2(STACK_DEPTH);
	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam logic [DATA_W-1:0] ONE_VAL = DATA_W'(1) << FRAC_BITS;

	typedef enum logic [2:0] {T_IDLE, T_READ, T_FETCH, T_WAIT, T_RESP} tstate_t;

	tstate_t           state_q;
	mode_t             mode_q;
	logic [CW-1:0]     count_q;
	logic [DATA_W-1:0] top_q;
	status_t           status_q;
	logic [AW-1:0]     rd_addr_q;
	logic              alu_go_q;
	alu_req_t          alu_req_q;
	alu_rsp_t          alu_rsp;

	mode_t             mode_in;
	logic              accept;
	logic              full;
	logic              binary_op;
	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [DATA_W-1:0] ram_wdata;
	logic [DATA_W-1:0] ram_rdata;

	assign mode_in   = mode_t'(mode);
	assign accept    = start && (state_q == T_IDLE);
	assign full      = (count_q == CW'(STACK_DEPTH));
	assign binary_op = (mode_q == MODE_ADD) || (mode_q == MODE_SUB) ||
	                   (mode_q == MODE_MUL) || (mode_q == MODE_DIV);

	// Stack writes: push on accept, or an arithmetic result landing in place.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = count_q[AW-1:0];
		ram_wdata = operand_value;
		if (accept && mode_in == MODE_PUSH && !full) begin
			ram_we = 1'b1;
		end else if (state_q == T_WAIT && alu_rsp.done) begin
			ram_we    = 1'b1;
			ram_wdata = alu_rsp.value;
			ram_waddr = binary_op ? AW'(count_q - CW'(2)) : AW'(count_q - CW'(1));
		end
	end

	rsc_ram #(
		.WIDTH (DATA_W),
		.DEPTH (STACK_DEPTH)
	) u_stack (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (rd_addr_q),
		.rdata (ram_rdata)
	);

	rsc_alu #(
		.FRAC_BITS (FRAC_BITS)
	) u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (alu_go_q),
		.req    (alu_req_q),
		.rsp    (alu_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= T_IDLE;
			count_q  <= '0;
			alu_go_q <= 1'b0;
			status_q <= ST_OK;
		end else begin
			alu_go_q <= 1'b0;
			unique case (state_q)
				T_IDLE: begin
					if (start) begin
						mode_q    <= mode_in;
						status_q  <= ST_OK;
						state_q   <= T_RESP;
						rd_addr_q <= AW'(count_q - CW'(2));
						alu_req_q.a <= ONE_VAL;
						alu_req_q.b <= top_q;
						unique case (mode_in)
							MODE_PUSH: begin
								if (full) begin
									status_q <= ST_FULL;
								end else begin
									top_q   <= operand_value;
									count_q <= count_q + CW'(1);
								end
							end
							MODE_ADD, MODE_SUB, MODE_MUL, MODE_DIV: begin
								// fetch next from the store, top is held locally
								if (count_q < CW'(2)) begin
									status_q <= ST_FEW;
								end else begin
									state_q <= T_READ;
								end
							end
							MODE_ABS, MODE_NEG, MODE_INV, MODE_SQR, MODE_SQRT: begin
								if (count_q == '0) begin
									status_q <= ST_FEW;
								end else if (mode_in == MODE_INV && top_q == '0) begin
									status_q <= ST_DIV0;
								end else if (mode_in == MODE_SQRT && top_q[DATA_W-1]) begin
									status_q <= ST_SQRTNEG;
								end else if (mode_in == MODE_ABS && !top_q[DATA_W-1]) begin
									status_q <= ST_OK;
								end else begin
									alu_go_q <= 1'b1;
									state_q  <= T_WAIT;
									unique case (mode_in)
										MODE_INV: alu_req_q.op <= ALU_DIV;
										MODE_SQR: begin
											alu_req_q.op <= ALU_MUL;
											alu_req_q.a  <= top_q;
										end
										MODE_SQRT: alu_req_q.op <= ALU_SQRT;
										default:   alu_req_q.op <= ALU_NEG;
									endcase
								end
							end
							MODE_DROP: begin
								// the new top must be read back when entries remain
								if (count_q == '0) begin
									status_q <= ST_FEW;
								end else begin
									count_q <= count_q - CW'(1);
									if (count_q >= CW'(2)) begin
										state_q <= T_READ;
									end
								end
							end
							MODE_CLEAR: count_q <= '0;
							default:    status_q <= ST_OK;
						endcase
					end
				end
				T_READ: state_q <= T_FETCH;
				T_FETCH: begin
					if (mode_q == MODE_DROP) begin
						top_q   <= ram_rdata;
						state_q <= T_RESP;
					end else if (mode_q == MODE_DIV && top_q == '0) begin
						status_q <= ST_DIV0;
						state_q  <= T_RESP;
					end else begin
						alu_req_q.a <= ram_rdata;
						alu_req_q.b <= top_q;
						case (mode_q)
							MODE_ADD: alu_req_q.op <= ALU_ADD;
							MODE_SUB: alu_req_q.op <= ALU_SUB;
							MODE_MUL: alu_req_q.op <= ALU_MUL;
							default:  alu_req_q.op <= ALU_DIV;
						endcase
						alu_go_q <= 1'b1;
						state_q  <= T_WAIT;
					end
				end
				T_WAIT: begin
					// hold until the shared unit reports, then retire the beat
					if (alu_rsp.done) begin
						top_q    <= alu_rsp.value;
						status_q <= alu_rsp.sat ? ST_SAT : ST_OK;
						if (binary_op) begin
							count_q <= count_q - CW'(1);
						end
						state_q <= T_RESP;
					end
				end
				T_RESP: state_q <= T_IDLE;
				default: state_q <= T_IDLE;
			endcase
		end
	end

	assign busy        = (state_q != T_IDLE);
	assign done        = (state_q == T_RESP);
	assign top_value   = (count_q != '0) ? top_q : '0;
	assign stack_count = count_q;
	assign status      = status_q;

endmodule

/* hdl/rsc_checker.sv */
// rsc_checker: port-level assertions for the RPN stack calculator, and the
// bind that attaches them to the top level. Depends on rsc_pkg.
module rsc_checker #(
	parameter int STACK_DEPTH = 16
) (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             start,
	input logic                             busy,
	input logic                             done,
	input logic [63:0]                      top_value,
	input logic [$clog2(STACK_DEPTH+1)-1:0] stack_count,
	input logic [2:0]                       status
);
	import rsc_pkg::*;

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted beat did not raise busy");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> stack_count <= ($clog2(STACK_DEPTH+1))'(STACK_DEPTH))
		else $error("stack count beyond depth");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && stack_count == '0 |-> top_value == '0)
		else $error("empty stack shows a nonzero top");

	a_full_flag: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == ST_FULL |-> stack_count == ($clog2(STACK_DEPTH+1))'(STACK_DEPTH))
		else $error("stack full flagged on a stack that is not full");

endmodule

bind rpn_stack_calculator rsc_checker #(.STACK_DEPTH(STACK_DEPTH)) u_rsc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.done        (done),
	.top_value   (top_value),
	.stack_count (stack_count),
	.status      (status)
);

/* bench/tb_top.sv */
// tb_top: self-checking bench for the RPN stack calculator.
// Depends on rsc_pkg and rpn_stack_calculator; drives command beats from a
// queue, predicts each result beat and compares it field by field.
`timescale 1ns / 100ps

module tb_top;
	import rsc_pkg::*;

	localparam int DEPTH   = 16;
	localparam int FRAC    = 32;
	localparam int LIMIT   = 900000;
	localparam logic [63:0] ONE_Q = 64'd1 << FRAC;
	localparam logic [3:0]  UNUSED_MODE = 4'd13;

	typedef struct {
		logic [3:0]  op;
		logic [63:0] val;
	} cmd_t;

	typedef struct {
		logic [63:0] top;
		logic [4:0]  cnt;
		logic [2:0]  st;
	} res_t;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [3:0]         mode;
	logic signed [63:0] operand_value;
	logic               done;
	logic signed [63:0] top_value;
	logic [4:0]         stack_count;
	logic [2:0]         status;

	cmd_t        cmd_q[$];
	res_t        want_q[$];
	logic [63:0] shadow[DEPTH];
	int          depth_now;
	int          n_errors;
	int          cycles;
	int          idle_pct;
	bit          hold_off;
	int          idle_pct_list[4] = '{0, 62, 0, 6};

	rpn_stack_calculator #(.STACK_DEPTH(DEPTH), .FRAC_BITS(FRAC)) u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.mode(mode), .operand_value(operand_value), .done(done),
		.top_value(top_value), .stack_count(stack_count), .status(status)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic logic [63:0] mag(logic [63:0] x);
		return x[63] ? -x : x;
	endfunction

	// Fit a 128-bit magnitude with sign into 64 bits; clamp on overflow
	function automatic logic [63:0] fit(logic [127:0] m, bit neg, ref bit sat);
		logic [127:0] lim;
		lim = neg ? {64'd0, MIN_NEG} : {64'd0, MAX_POS};
		if (m > lim) begin
			sat = 1;
			return lim[63:0];
		end
		return neg ? -m[63:0] : m[63:0];
	endfunction

	function automatic logic [63:0] q_mul(logic [63:0] a, logic [63:0] b, ref bit sat);
		logic [127:0] p;
		p = ({64'd0, mag(a)} * {64'd0, mag(b)}) >> FRAC;
		return fit(p, a[63] ^ b[63], sat);
	endfunction

	function automatic logic [63:0] q_div(logic [63:0] n, logic [63:0] d, ref bit sat);
		logic [127:0] q;
		q = ({64'd0, mag(n)} << FRAC) / {64'd0, mag(d)};
		return fit(q, n[63] ^ d[63], sat);
	endfunction

	// Floor root of x scaled up by the fraction bits, bit by bit
	function automatic logic [63:0] q_sqrt(logic [63:0] x);
		logic [127:0] tgt;
		logic [63:0]  root;
		logic [63:0]  cand;
		tgt  = {64'd0, x} << FRAC;
		root = '0;
		for (int b = 62; b >= 0; b--) begin
			cand = root | (64'd1 << b);
			if ({64'd0, cand} * {64'd0, cand} <= tgt)
				root = cand;
		end
		return root;
	endfunction

	function automatic logic [63:0] q_neg(logic [63:0] a, ref bit sat);
		if (a == MIN_NEG) begin
			sat = 1;
			return MAX_POS;
		end
		return -a;
	endfunction

	// Advance the shadow stack by one command and return the result beat
	function automatic res_t calc_step(cmd_t c);
		res_t        r;
		bit          sat;
		logic [2:0]  st;
		logic [63:0] t, nx, v;
		int          n;
		sat = 0;
		st  = ST_OK;
		n   = depth_now;
		t   = (n > 0) ? shadow[n-1] : '0;
		nx  = (n > 1) ? shadow[n-2] : '0;
		case (c.op)
			MODE_PUSH: begin
				if (n >= DEPTH) st = ST_FULL;
				else begin
					shadow[n] = c.val;
					n++;
				end
			end
			MODE_ADD, MODE_SUB, MODE_MUL, MODE_DIV: begin
				if (n < 2) st = ST_FEW;
				else if (c.op == MODE_DIV && t == 0) st = ST_DIV0;
				else begin
					case (c.op)
						MODE_ADD: begin
							v = nx + t;
							if (nx[63] == t[63] && v[63] != nx[63]) begin
								sat = 1;
								v = nx[63] ? MIN_NEG : MAX_POS;
							end
						end
						MODE_SUB: begin
							v = nx - t;
							if (nx[63] != t[63] && v[63] != nx[63]) begin
								sat = 1;
								v = nx[63] ? MIN_NEG : MAX_POS;
							end
						end
						MODE_MUL: v = q_mul(nx, t, sat);
						default:  v = q_div(nx, t, sat);
					endcase
					shadow[n-2] = v;
					n--;
				end
			end
			MODE_ABS, MODE_NEG, MODE_INV, MODE_SQR, MODE_SQRT: begin
				if (n < 1) st = ST_FEW;
				else case (c.op)
					MODE_ABS: shadow[n-1] = t[63] ? q_neg(t, sat) : t;
					MODE_NEG: shadow[n-1] = q_neg(t, sat);
					MODE_INV: begin
						if (t == 0) st = ST_DIV0;
						else shadow[n-1] = q_div(ONE_Q, t, sat);
					end
					MODE_SQR: shadow[n-1] = q_mul(t, t, sat);
					default: begin
						if (t[63]) st = ST_SQRTNEG;
						else shadow[n-1] = q_sqrt(t);
					end
				endcase
			end
			MODE_DROP: begin
				if (n < 1) st = ST_FEW;
				else n--;
			end
			MODE_CLEAR: n = 0;
			default: ;
		endcase
		if (sat && st == ST_OK) st = ST_SAT;
		depth_now = n;
		r.top = (n > 0) ? shadow[n-1] : '0;
		r.cnt = n[4:0];
		r.st  = st;
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] exp);
		$display("tb_top: mismatch %s got %h want %h at %0t", what, got, exp, $realtime);
		n_errors++;
	endtask

	function automatic logic [63:0] rand_q();
		logic [63:0] v;
		v = {$urandom, $urandom};
		case ($urandom_range(0, 7))
			0: v = MAX_POS;
			1: v = MIN_NEG;
			2: v = '0;
			3: v = ONE_Q;
			4: v = -ONE_Q;
			5, 6: v = $signed({{32{v[31]}}, v[31:0]}) >>> $urandom_range(0, 20);
			default: ;
		endcase
		return v;
	endfunction

	// Driver: raise start with the next queued beat, hold it until accepted
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start         <= 1'b0;
			mode          <= '0;
			operand_value <= '0;
		end else begin
			if (start && !busy) begin
				// beat taken: compute its expected result now
				want_q.push_back(calc_step('{mode, operand_value}));
			end
			if (!(start && busy)) begin
				if (cmd_q.size() > 0 && !hold_off
				    && $urandom_range(0, 99) >= idle_pct) begin
					start         <= 1'b1;
					mode          <= cmd_q[0].op;
					operand_value <= cmd_q[0].val;
					void'(cmd_q.pop_front());
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Monitor: every done strobe must meet the oldest expectation
	always @(posedge clk) begin
		res_t w;
		if (arst_n && done) begin
			if (want_q.size() == 0) begin
				report_mismatch("unexpected beat", top_value, '0);
			end else begin
				w = want_q.pop_front();
				if (top_value !== w.top) report_mismatch("top_value", top_value, w.top);
				if (stack_count !== w.cnt) report_mismatch("stack_count", stack_count, w.cnt);
				if (status !== w.st) report_mismatch("status", status, w.st);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("tb_top: errors");
			$finish;
		end
	end

	task automatic add_cmd(logic [3:0] op, logic [63:0] v);
		cmd_q.push_back('{op, v});
	endtask

	// Look between edges so that the driver and monitor have settled
	task automatic drain();
		while (cmd_q.size() > 0 || start || want_q.size() > 0)
			@(negedge clk);
	endtask

	// Mostly well-formed run: push one to three operands then apply a random operation
	task automatic add_random(int count);
		int k;
		k = 0;
		while (k < count) begin
			if ($urandom_range(0, 9) < 8) begin
				repeat ($urandom_range(1, 3)) begin
					add_cmd(MODE_PUSH, rand_q());
					k++;
				end
				add_cmd(4'($urandom_range(MODE_ADD, MODE_SQRT)), {$urandom, $urandom});
			end else begin
				// noise of drops, clears and unused codes
				add_cmd(4'($urandom_range(MODE_DROP, 15)), {$urandom, $urandom});
			end
			k++;
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		n_errors      = 0;
		cycles        = 0;
		depth_now     = 0;
		idle_pct      = 0;
		hold_off      = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Directed cases for empty-stack errors, extremes, saturation, zero divisor, overfill and an unused mode
		add_cmd(MODE_ADD, '0);
		add_cmd(MODE_SQRT, '0);
		add_cmd(MODE_DROP, '0);
		add_cmd(MODE_PUSH, MAX_POS);
		add_cmd(MODE_PUSH, MAX_POS);
		add_cmd(MODE_ADD, '0);
		add_cmd(MODE_PUSH, MIN_NEG);
		add_cmd(MODE_ABS, '0);
		add_cmd(MODE_NEG, '0);
		add_cmd(MODE_SQRT, '0);
		add_cmd(MODE_PUSH, '0);
		add_cmd(MODE_INV, '0);
		add_cmd(MODE_DIV, '0);
		add_cmd(MODE_PUSH, -ONE_Q);
		add_cmd(MODE_SUB, '0);
		add_cmd(MODE_SQRT, '0);
		add_cmd(MODE_SQR, '0);
		add_cmd(MODE_MUL, '0);
		add_cmd(MODE_INV, '0);
		add_cmd(MODE_CLEAR, '0);
		for (int i = 0; i < DEPTH + 1; i++) add_cmd(MODE_PUSH, {$urandom, $urandom});
		add_cmd(UNUSED_MODE, '1);
		add_cmd(MODE_CLEAR, '0);
		drain();

		// Pause until everything has drained, then run the idle phases
		hold_off = 1;
		repeat (10) @(posedge clk);
		hold_off = 0;
		foreach (idle_pct_list[i]) begin
			idle_pct = idle_pct_list[i];
			add_random(225);
			drain();
		end
		repeat (100) @(posedge clk);
		if (n_errors == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule
